// File: rtl/stcc_pkg.sv
`default_nettype none
package stcc_pkg;

    localparam logic [7:0] CENTER = 8'd128;

    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_SENSOR = 2'd1;
    localparam logic [1:0] CMD_TX     = 2'd2;
    localparam logic [1:0] CMD_MS     = 2'd3;

    localparam logic [2:0] CFG_ENGAGED_MODE    = 3'd0;
    localparam logic [2:0] CFG_KEY_STEP        = 3'd1;
    localparam logic [2:0] CFG_OFFSET_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_SLEW_RATE       = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT_MS      = 3'd4;
    localparam logic [2:0] CFG_SPIKE_THRESHOLD = 3'd5;

    localparam logic [7:0] KEY_LEFT_LO  = 8'h61;
    localparam logic [7:0] KEY_LEFT_UP  = 8'h41;
    localparam logic [7:0] KEY_RIGHT_LO = 8'h64;
    localparam logic [7:0] KEY_RIGHT_UP = 8'h44;
    localparam logic [7:0] KEY_SPACE    = 8'h20;
    localparam logic [7:0] KEY_STOP_LO  = 8'h78;
    localparam logic [7:0] KEY_STOP_UP  = 8'h58;
    localparam logic [7:0] KEY_SAFE     = 8'h73;

    typedef struct packed {
        logic [2:0]  engaged_mode;
        logic [6:0]  key_step;
        logic [6:0]  offset_limit;
        logic [12:0] slew_rate;
        logic [19:0] timeout_ms;
        logic [7:0]  spike_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        engaged_mode:    3'd1,
        key_step:        7'd6,
        offset_limit:    7'd30,
        slew_rate:       13'd77,
        timeout_ms:      20'd3000,
        spike_threshold: 8'd12
    };

endpackage
`default_nettype wire

// File: rtl/stcc_slew.sv
`default_nettype none
module stcc_slew #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                   i_enable,
    input  wire logic [FRAC_BITS+7:0]   i_applied,
    input  wire logic [7:0]             i_goal,
    input  wire logic [12:0]            i_slew,
    output logic      [FRAC_BITS+7:0]   o_applied,
    output logic      [7:0]             o_torque
);
    localparam int AW = FRAC_BITS + 8;
    localparam int SW = ((AW > 13) ? AW : 13) + 1;

    logic [AW-1:0] w_goal;
    logic [SW-1:0] w_app_x;
    logic [SW-1:0] w_goal_x;
    logic [SW-1:0] w_slew_x;
    logic [AW-1:0] w_next;
    logic [AW:0]   w_round;

    assign w_goal   = {i_goal, {FRAC_BITS{1'b0}}};
    assign w_app_x  = SW'(i_applied);
    assign w_goal_x = SW'(w_goal);
    assign w_slew_x = SW'(i_slew);

    always_comb begin
        w_next = i_applied;
        if (i_enable) begin
            if (w_app_x < w_goal_x) begin
                w_next = ((w_goal_x - w_app_x) > w_slew_x) ? AW'(w_app_x + w_slew_x) : w_goal;
            end else if (w_app_x > w_goal_x) begin
                w_next = ((w_app_x - w_goal_x) > w_slew_x) ? AW'(w_app_x - w_slew_x) : w_goal;
            end
        end
    end

    // round half up and drop the fraction
    assign w_round   = {1'b0, w_next} + (AW+1)'(2 ** (FRAC_BITS - 1));
    assign o_applied = w_next;
    assign o_torque  = w_round[FRAC_BITS+7:FRAC_BITS];
endmodule
`default_nettype wire

// File: rtl/steer_torque_command_controller.sv
`default_nettype none
// Steering torque command controller. One item enters per clock: key bytes, torque sensor
// frames, 100 Hz transmit ticks and millisecond ticks, selected by the input tuser code.
// Every item yields exactly one result item, passing the input register and then a
// single-pass state update into the result register; sustained throughput is one item
// per cycle, limited only by output back-pressure, which stalls both stages together.
// A result with tuser set is a command frame; mode_byte and torque_byte always report the
// state after the item. Configuration writes are taken in any cycle and apply at once.
module steer_torque_command_controller #(
    parameter int FRAC_BITS = 8,
    parameter int IDLE_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // key_code, sensor_a, sensor_b
    input  wire logic [1:0]  i_s_tuser,  // command
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [15:0] o_m_tdata,  // mode_byte, torque_byte, override_hit, deadman_hit
    output logic             o_m_tuser,  // frame_valid
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);
    import stcc_pkg::*;

    localparam int AW = FRAC_BITS + 8;
    localparam int CW = (IDLE_BITS > 20) ? IDLE_BITS : 20;

    t_cfg r_cfg;

    logic           r_in_valid;
    logic [1:0]     r_in_cmd;
    logic [7:0]     r_in_key;
    logic [7:0]     r_in_sa;
    logic [7:0]     r_in_sb;

    logic [2:0]           r_mode;
    logic [7:0]           r_target;
    logic [AW-1:0]        r_applied;
    logic [IDLE_BITS-1:0] r_idle;
    logic                 r_seen;
    logic [7:0]           r_base_a;
    logic [7:0]           r_base_b;

    logic [2:0]           n_mode;
    logic [7:0]           n_target;
    logic [IDLE_BITS-1:0] n_idle;
    logic                 n_seen;
    logic [7:0]           n_base_a;
    logic [7:0]           n_base_b;
    logic                 n_override;
    logic                 n_deadman;

    logic           r_out_valid;
    logic           r_out_frame;
    logic [2:0]     r_out_mode;
    logic [7:0]     r_out_torque;
    logic           r_out_override;
    logic           r_out_deadman;

    logic           w_adv;
    logic           w_step;
    logic           w_left;
    logic           w_right;
    logic signed [9:0] w_sum;
    logic signed [9:0] w_hi;
    logic signed [9:0] w_lo;
    logic [7:0]     w_clamped;
    logic [7:0]     w_da;
    logic [7:0]     w_db;
    logic [7:0]     w_goal;
    logic [AW-1:0]  w_applied;
    logic [7:0]     w_torque;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_step     = r_in_valid && w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENGAGED_MODE:    r_cfg.engaged_mode    <= i_cfg_data[2:0];
                CFG_KEY_STEP:        r_cfg.key_step        <= i_cfg_data[6:0];
                CFG_OFFSET_LIMIT:    r_cfg.offset_limit    <= i_cfg_data[6:0];
                CFG_SLEW_RATE:       r_cfg.slew_rate       <= i_cfg_data[12:0];
                CFG_TIMEOUT_MS:      r_cfg.timeout_ms      <= i_cfg_data;
                CFG_SPIKE_THRESHOLD: r_cfg.spike_threshold <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_cmd <= i_s_tuser;
            r_in_key <= i_s_tdata[7:0];
            r_in_sa  <= i_s_tdata[15:8];
            r_in_sb  <= i_s_tdata[23:16];
        end
    end

    // steer keys with clamp around center
    assign w_left  = (r_in_key == KEY_LEFT_LO) || (r_in_key == KEY_LEFT_UP);
    assign w_right = (r_in_key == KEY_RIGHT_LO) || (r_in_key == KEY_RIGHT_UP);
    assign w_hi    = $signed({2'b00, CENTER}) + $signed({3'b000, r_cfg.offset_limit});
    assign w_lo    = $signed({2'b00, CENTER}) - $signed({3'b000, r_cfg.offset_limit});
    assign w_sum   = w_left ? $signed({2'b00, r_target}) - $signed({3'b000, r_cfg.key_step})
                            : $signed({2'b00, r_target}) + $signed({3'b000, r_cfg.key_step});

    always_comb begin
        priority if (w_sum > w_hi) begin
            w_clamped = w_hi[7:0];
        end else if (w_sum < w_lo) begin
            w_clamped = w_lo[7:0];
        end else begin
            w_clamped = w_sum[7:0];
        end
    end

    assign w_goal = (r_mode == 3'd0) ? CENTER : r_target;

    stcc_slew #(
        .FRAC_BITS (FRAC_BITS)
    ) u_slew (
        .i_enable  (r_in_cmd == CMD_TX),
        .i_applied (r_applied),
        .i_goal    (w_goal),
        .i_slew    (r_cfg.slew_rate),
        .o_applied (w_applied),
        .o_torque  (w_torque)
    );

    always_comb begin
        n_mode     = r_mode;
        n_target   = r_target;
        n_idle     = r_idle;
        n_seen     = r_seen;
        n_base_a   = r_base_a;
        n_base_b   = r_base_b;
        n_override = 1'b0;
        n_deadman  = 1'b0;
        w_da       = 8'd0;
        w_db       = 8'd0;
        unique case (r_in_cmd)
            CMD_KEY: begin
                n_idle = '0;
                priority if (w_left || w_right) begin
                    n_mode   = r_cfg.engaged_mode;
                    n_target = w_clamped;
                end else if (r_in_key == KEY_SPACE) begin
                    n_target = CENTER;
                end else if ((r_in_key == KEY_STOP_LO) || (r_in_key == KEY_STOP_UP)
                             || (r_in_key == KEY_SAFE)) begin
                    n_mode   = 3'd0;
                    n_target = CENTER;
                end
            end
            CMD_SENSOR: begin
                if (!r_seen) begin
                    n_seen   = 1'b1;
                    n_base_a = r_in_sa;
                    n_base_b = r_in_sb;
                end
                w_da = (r_in_sa > n_base_a) ? r_in_sa - n_base_a : n_base_a - r_in_sa;
                w_db = (r_in_sb > n_base_b) ? r_in_sb - n_base_b : n_base_b - r_in_sb;
                if (((w_da > r_cfg.spike_threshold) || (w_db > r_cfg.spike_threshold))
                    && (r_mode != 3'd0)) begin
                    n_mode     = 3'd0;
                    n_target   = CENTER;
                    n_override = 1'b1;
                end
            end
            CMD_TX: ;
            CMD_MS: begin
                if (r_idle != '1) begin
                    n_idle = r_idle + IDLE_BITS'(1);
                end
            end
            default: ;
        endcase
        // deadman
        if ((n_mode != 3'd0) && (CW'(n_idle) > CW'(r_cfg.timeout_ms))) begin
            n_target = CENTER;
            if (w_torque == CENTER) begin
                n_mode    = 3'd0;
                n_deadman = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 3'd0;
            r_target  <= CENTER;
            r_applied <= {CENTER, {FRAC_BITS{1'b0}}};
            r_idle    <= '0;
            r_seen    <= 1'b0;
            r_base_a  <= CENTER;
            r_base_b  <= CENTER;
        end else if (w_step) begin
            r_mode    <= n_mode;
            r_target  <= n_target;
            r_applied <= w_applied;
            r_idle    <= n_idle;
            r_seen    <= n_seen;
            r_base_a  <= n_base_a;
            r_base_b  <= n_base_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_frame    <= (r_in_cmd == CMD_TX);
            r_out_mode     <= n_mode;
            r_out_torque   <= w_torque;
            r_out_override <= n_override;
            r_out_deadman  <= n_deadman;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_frame;
    assign o_m_tdata  = {3'b000, r_out_deadman, r_out_override, r_out_torque, r_out_mode};

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("accepted item produced no result");

    a_deadman_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_deadman) |-> ((r_out_mode == 3'd0) && (r_out_torque == CENTER)))
        else $error("deadman result not safe at center");

    a_override_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_override) |-> ((r_out_mode == 3'd0) && !r_out_frame))
        else $error("override result inconsistent");

endmodule
`default_nettype wire

// File: tb/sv/steer_torque_checker.sv
module steer_torque_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [23:0] i_s_tdata,  // key_code, sensor_a, sensor_b
    input  wire logic [1:0]  i_s_tuser,  // command
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,  // mode_byte, torque_byte, override_hit, deadman_hit
    input  wire logic        i_m_tuser,  // frame_valid
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    output int               o_pending,
    output int               o_errors,
    output int               o_overrides,
    output int               o_deadman_trips
);
    import stcc_pkg::*;

    localparam int FRAC = 8;
    localparam logic [19:0] IDLE_CEILING = 20'hFFFFF;

    typedef struct packed {
        logic       frame;
        logic [2:0] mode;
        logic [7:0] torque;
        logic       override_hit;
        logic       deadman_hit;
    } t_torque_result;

    t_cfg           settings;
    logic [2:0]     drive_mode;
    logic [7:0]     torque_target;
    logic [15:0]    applied_fx;
    logic [19:0]    idle_ms;
    logic           baseline_valid;
    logic [7:0]     baseline_a;
    logic [7:0]     baseline_b;
    t_torque_result torque_q[$];
    int             mismatches;
    int             override_count;
    int             deadman_count;

    assign o_errors        = mismatches;
    assign o_overrides     = override_count;
    assign o_deadman_trips = deadman_count;

    function automatic logic [7:0] torque_now();
        logic [16:0] sum;
        sum = {1'b0, applied_fx} + (17'd1 << (FRAC - 1));
        return sum[15:8];
    endfunction

    function automatic logic [7:0] sensor_gap(logic [7:0] a, logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void steer_by(int delta);
        int v;
        int hi;
        int lo;
        v  = int'(torque_target) + delta;
        hi = int'(CENTER) + int'(settings.offset_limit);
        lo = int'(CENTER) - int'(settings.offset_limit);
        drive_mode = settings.engaged_mode;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        torque_target = 8'(v);
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [19:0] data);
        case (idx)
            CFG_ENGAGED_MODE:    settings.engaged_mode    = data[2:0];
            CFG_KEY_STEP:        settings.key_step        = data[6:0];
            CFG_OFFSET_LIMIT:    settings.offset_limit    = data[6:0];
            CFG_SLEW_RATE:       settings.slew_rate       = data[12:0];
            CFG_TIMEOUT_MS:      settings.timeout_ms      = data[19:0];
            CFG_SPIKE_THRESHOLD: settings.spike_threshold = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic t_torque_result apply_item(logic [1:0] cmd, logic [7:0] key,
                                                  logic [7:0] sa, logic [7:0] sb);
        t_torque_result r;
        logic [16:0]    goal;
        logic [16:0]    now17;
        r = '0;
        case (cmd)
            CMD_KEY: begin
                idle_ms = '0;
                if (key == KEY_LEFT_LO || key == KEY_LEFT_UP) begin
                    steer_by(-int'(settings.key_step));
                end else if (key == KEY_RIGHT_LO || key == KEY_RIGHT_UP) begin
                    steer_by(int'(settings.key_step));
                end else if (key == KEY_SPACE) begin
                    torque_target = CENTER;
                end else if (key == KEY_STOP_LO || key == KEY_STOP_UP || key == KEY_SAFE) begin
                    drive_mode    = '0;
                    torque_target = CENTER;
                end
            end
            CMD_SENSOR: begin
                if (!baseline_valid) begin
                    baseline_a     = sa;
                    baseline_b     = sb;
                    baseline_valid = 1'b1;
                end
                if ((sensor_gap(sa, baseline_a) > settings.spike_threshold ||
                     sensor_gap(sb, baseline_b) > settings.spike_threshold) &&
                    drive_mode != '0) begin
                    drive_mode     = '0;
                    torque_target  = CENTER;
                    r.override_hit = 1'b1;
                end
            end
            CMD_TX: begin
                goal  = 17'((drive_mode == '0) ? CENTER : torque_target) << FRAC;
                now17 = {1'b0, applied_fx};
                if (now17 < goal) begin
                    applied_fx = (goal - now17 > 17'(settings.slew_rate)) ?
                                 applied_fx + 16'(settings.slew_rate) : goal[15:0];
                end else if (now17 > goal) begin
                    applied_fx = (now17 - goal > 17'(settings.slew_rate)) ?
                                 applied_fx - 16'(settings.slew_rate) : goal[15:0];
                end
                r.frame = 1'b1;
            end
            default: begin
                if (idle_ms < IDLE_CEILING) idle_ms = idle_ms + 20'd1;
            end
        endcase
        // deadman: recenter, then drop to safe once the torque reads center
        if (drive_mode != '0 && idle_ms > settings.timeout_ms) begin
            torque_target = CENTER;
            if (torque_now() == CENTER) begin
                drive_mode    = '0;
                r.deadman_hit = 1'b1;
            end
        end
        r.mode   = drive_mode;
        r.torque = torque_now();
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_torque_result seen;
        t_torque_result want;
        if (!i_rst_n) begin
            settings       = CFG_RESET;
            drive_mode     = '0;
            torque_target  = CENTER;
            applied_fx     = 16'(CENTER) << FRAC;
            idle_ms        = '0;
            baseline_valid = 1'b0;
            baseline_a     = CENTER;
            baseline_b     = CENTER;
            torque_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_reg(i_cfg_index, i_cfg_data);
            if (i_m_tvalid && i_m_tready) begin
                seen.frame        = i_m_tuser;
                seen.mode         = i_m_tdata[2:0];
                seen.torque       = i_m_tdata[10:3];
                seen.override_hit = i_m_tdata[11];
                seen.deadman_hit  = i_m_tdata[12];
                if (torque_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no item pending, expected none, actual %h/%b",
                             $time, i_m_tdata, i_m_tuser);
                end else begin
                    want = torque_q.pop_front();
                    compare_field("frame_valid", want.frame, seen.frame);
                    compare_field("mode_byte", want.mode, seen.mode);
                    compare_field("torque_byte", want.torque, seen.torque);
                    compare_field("override_hit", want.override_hit, seen.override_hit);
                    compare_field("deadman_hit", want.deadman_hit, seen.deadman_hit);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = apply_item(i_s_tuser, i_s_tdata[7:0], i_s_tdata[15:8],
                                  i_s_tdata[23:16]);
                if (want.override_hit) override_count++;
                if (want.deadman_hit) deadman_count++;
                torque_q.push_back(want);
            end
        end
        o_pending <= torque_q.size();
    end

endmodule

// File: tb/sv/steer_torque_command_controller_test.sv
module steer_torque_command_controller_test;
    import stcc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES = 13;
    localparam int ITEMS_PER_PHASE = 130;
    localparam logic [7:0] BASE_A = 8'd100;
    localparam logic [7:0] BASE_B = 8'd160;
    localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  idx;
        logic [19:0] data;
    } t_reg_write;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_KEY;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_ENGAGED_MODE;
    logic [19:0] cfg_data = '0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [15:0] m_tdata;
    wire logic        m_tuser;
    wire logic        cfg_ready;

    int pending;
    int errors;
    int overrides;
    int deadman_trips;

    int cycles = 0;
    int sink_hold = 0;
    logic sink_steady = 1'b0;
    logic src_steady = 1'b0;
    int cur_threshold = 12;
    int key_pct = 30;
    int n_keys = 0;
    int n_sensor = 0;
    int n_tx = 0;
    int n_ms = 0;
    int n_settings = 0;
    t_reg_write reg_plan[$];

    steer_torque_command_controller u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    steer_torque_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_errors        (errors),
        .o_overrides     (overrides),
        .o_deadman_trips (deadman_trips)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk) begin : sink
        int hold;
        if (!rst_n) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            hold = sink_steady ? 0 : $urandom_range(0, 13);
            sink_hold <= hold;
            m_tready  <= (hold == 0);
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= (sink_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [7:0] key, logic [7:0] sa, logic [7:0] sb);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sb, sa, key};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        case (cmd)
            CMD_KEY:    n_keys++;
            CMD_SENSOR: n_sensor++;
            CMD_TX:     n_tx++;
            default:    n_ms++;
        endcase
    endtask

    task automatic send_key(logic [7:0] key);
        send_item(CMD_KEY, key, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_sensor(logic [7:0] sa, logic [7:0] sb);
        send_item(CMD_SENSOR, 8'($urandom), sa, sb);
    endtask

    task automatic send_tick(logic [1:0] cmd);
        send_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // upper data bits are noise, the block keeps only the register width
    task automatic stage_reg(logic [2:0] idx, int value, int width);
        t_reg_write w;
        logic [19:0] keep;
        keep   = (20'd1 << width) - 20'd1;
        w.idx  = idx;
        w.data = (20'($urandom) & ~keep) | (20'(value) & keep);
        reg_plan.push_back(w);
        if (idx == CFG_SPIKE_THRESHOLD) cur_threshold = value;
    endtask

    task automatic load_regs();
        drain();
        foreach (reg_plan[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_plan[i].idx;
            cfg_data  <= reg_plan[i].data;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        reg_plan.delete();
        n_settings++;
    endtask

    task automatic plan_settings(int phase);
        int em;
        int ks;
        int ol;
        int sr;
        int tm;
        int th;
        em = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 5) : $urandom_range(0, 7);
        ks = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 64) : $urandom_range(0, 127);
        ol = $urandom_range(0, 127);
        case ($urandom_range(0, 9))
            0:       sr = 0;
            1, 2:    sr = $urandom_range(513, 8191);
            default: sr = $urandom_range(1, 512);
        endcase
        case ($urandom_range(0, 9))
            0:       tm = 20'hFFFFF - $urandom_range(0, 3);
            1, 2:    tm = $urandom_range(13, 200);
            default: tm = $urandom_range(1, 12);
        endcase
        th = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40) : $urandom_range(0, 255);
        case (phase)
            0: begin em = 5; ks = 64;  ol = 127; sr = 4096; tm = 1;        th = 0;   end
            1: begin em = 1; ks = 0;   ol = 0;   sr = 1;    tm = 20'hFFFFF; th = 255; end
            2: begin em = 7; ks = 127; ol = 127; sr = 8191; tm = 1;        th = 255; end
            3: begin em = 3; ks = 6;   ol = 30;  sr = 0;    tm = 4;        th = 12;  end
            default: ;
        endcase
        stage_reg(CFG_ENGAGED_MODE, em, 3);
        stage_reg(CFG_KEY_STEP, ks, 7);
        stage_reg(CFG_OFFSET_LIMIT, ol, 7);
        stage_reg(CFG_SLEW_RATE, sr, 13);
        stage_reg(CFG_TIMEOUT_MS, tm, 20);
        stage_reg(CFG_SPIKE_THRESHOLD, th, 8);
    endtask

    function automatic logic [7:0] near_base(logic [7:0] base);
        int spread;
        int v;
        spread = cur_threshold + 1;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic random_item();
        int pick;
        int r;
        logic [7:0] key;
        pick = $urandom_range(0, 99);
        if (pick < key_pct) begin
            r = $urandom_range(0, 99);
            if (r < 15)      key = KEY_LEFT_LO;
            else if (r < 30) key = KEY_LEFT_UP;
            else if (r < 45) key = KEY_RIGHT_LO;
            else if (r < 60) key = KEY_RIGHT_UP;
            else if (r < 68) key = KEY_SPACE;
            else if (r < 72) key = KEY_STOP_LO;
            else if (r < 76) key = KEY_STOP_UP;
            else if (r < 80) key = KEY_SAFE;
            else             key = 8'($urandom);
            send_key(key);
        end else if (pick < key_pct + 15) begin
            if ($urandom_range(0, 4) != 0) send_sensor(near_base(BASE_A), near_base(BASE_B));
            else send_sensor(8'($urandom), 8'($urandom));
        end else if (pick < key_pct + 15 + (85 - key_pct) / 2) begin
            send_tick(CMD_TX);
        end else begin
            send_tick(CMD_MS);
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: baseline, keys, override and its limits
        send_sensor(BASE_A, BASE_B);
        send_key(8'h00);
        send_key(KEY_RIGHT_LO);
        send_tick(CMD_TX);
        send_tick(CMD_TX);
        send_sensor(BASE_A + 8'd12, BASE_B - 8'd12);
        send_sensor(BASE_A, BASE_B + 8'd13);
        send_key(KEY_LEFT_UP);
        send_key(KEY_LEFT_LO);
        send_tick(CMD_MS);
        send_tick(CMD_TX);
        send_key(KEY_SPACE);
        send_key(KEY_RIGHT_UP);
        send_key(KEY_STOP_UP);
        send_sensor(8'hFF, 8'h00);
        send_tick(CMD_TX);
        send_key(KEY_RIGHT_LO);
        send_key(KEY_STOP_LO);
        send_key(KEY_SAFE);
        send_key(8'hFF);

        // engaged mode zero stays safe, then deadman with a short timeout
        stage_reg(CFG_ENGAGED_MODE, 0, 3);
        stage_reg(CFG_KEY_STEP, 64, 7);
        stage_reg(CFG_OFFSET_LIMIT, 127, 7);
        stage_reg(CFG_SLEW_RATE, 4096, 13);
        stage_reg(CFG_TIMEOUT_MS, 1, 20);
        stage_reg(CFG_SPIKE_THRESHOLD, 0, 8);
        stage_reg(CFG_UNMAPPED_LO, $urandom, 20);
        stage_reg(CFG_UNMAPPED_HI, $urandom, 20);
        load_regs();
        send_key(KEY_RIGHT_LO);
        send_tick(CMD_TX);
        stage_reg(CFG_ENGAGED_MODE, 5, 3);
        load_regs();
        send_key(KEY_RIGHT_UP);
        send_tick(CMD_TX);
        send_tick(CMD_MS);
        send_tick(CMD_MS);
        send_tick(CMD_TX);

        for (int phase = 0; phase < PHASES; phase++) begin
            plan_settings(phase);
            load_regs();
            src_steady   = (phase % 4 == 1);
            sink_steady <= (phase % 4 == 2);
            key_pct      = (phase % 3 == 2) ? 8 : 30;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) random_item();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("sent %0d keys, %0d sensor frames, %0d tx ticks, %0d ms ticks over %0d settings",
                 n_keys, n_sensor, n_tx, n_ms, n_settings);
        $display("%0d overrides and %0d deadman drops seen, %0d mismatches",
                 overrides, deadman_trips, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
